// ===== hw/rtl/rmth_pkg.sv =====
// Shared types, widths and the heap ordering compare for the running median unit.
// No dependencies.
package rmth_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned MedW   = 33;
  localparam int unsigned CountW = 11;

  // control group passed from the sequencer to the sift engine
  typedef struct packed {
    logic start;
    logic is_max;
    logic down;
  } heap_cmd_t;

  // true when a must sit above b in a max-heap (is_max) or a min-heap
  function automatic logic outranks(logic signed [DataW-1:0] a,
                                    logic signed [DataW-1:0] b,
                                    logic is_max);
    outranks = is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ===== hw/rtl/rmth_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/rmth_sift.sv =====
// Sift engine: moves a value from a hole up or down one heap held in RAM.
// Depends on rmth_pkg.
module rmth_sift #(
  parameter int unsigned Slots = 513
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rmth_pkg::heap_cmd_t                   cmd_i,
  input  logic [$clog2(Slots)-1:0]              idx_i,
  input  logic [$clog2(Slots+1)-1:0]            n_i,
  input  logic signed [rmth_pkg::DataW-1:0]     x_i,
  output logic                                  done_o,
  output logic                                  sel_lower_o,
  output logic                                  we_o,
  output logic [$clog2(Slots)-1:0]              waddr_o,
  output logic [rmth_pkg::DataW-1:0]            wdata_o,
  output logic                                  re_o,
  output logic [$clog2(Slots)-1:0]              raddr_o,
  input  logic signed [rmth_pkg::DataW-1:0]     rdata_i
);

  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned SW = $clog2(Slots + 1);
  localparam int unsigned CW = AW + 2;

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_UPRD  = 3'd1;
  localparam logic [2:0] E_UPCMP = 3'd2;
  localparam logic [2:0] E_DNL   = 3'd3;
  localparam logic [2:0] E_DNR   = 3'd4;
  localparam logic [2:0] E_DNCMP = 3'd5;

  logic [2:0]                          state_q, state_d;
  logic                                is_max_q, is_max_d;
  logic [AW-1:0]                       i_q, i_d;
  logic [SW-1:0]                       n_q, n_d;
  logic signed [rmth_pkg::DataW-1:0]   x_q, x_d;
  logic signed [rmth_pkg::DataW-1:0]   cl_q, cl_d;
  logic                                have_r_q, have_r_d;

  logic [AW-1:0]                       parent;
  logic [CW-1:0]                       left_w, right_w, n_w;
  logic                                pick_l, pick_r;
  logic signed [rmth_pkg::DataW-1:0]   best_l;

  assign parent  = AW'((i_q - AW'(1)) >> 1);
  assign left_w  = CW'({i_q, 1'b1});
  assign right_w = left_w + CW'(1);
  assign n_w     = CW'(n_q);
  assign pick_l  = rmth_pkg::outranks(cl_q, x_q, is_max_q);
  assign best_l  = pick_l ? cl_q : x_q;
  assign pick_r  = have_r_q && rmth_pkg::outranks(rdata_i, best_l, is_max_q);
  assign sel_lower_o = is_max_q;

  always_comb begin
    state_d  = state_q;
    is_max_d = is_max_q;
    i_d      = i_q;
    n_d      = n_q;
    x_d      = x_q;
    cl_d     = cl_q;
    have_r_d = have_r_q;
    done_o   = 1'b0;
    we_o     = 1'b0;
    waddr_o  = i_q;
    wdata_o  = x_q;
    re_o     = 1'b0;
    raddr_o  = parent;
    unique case (state_q)
      E_IDLE: begin
        if (cmd_i.start) begin
          is_max_d = cmd_i.is_max;
          i_d      = idx_i;
          n_d      = n_i;
          x_d      = x_i;
          state_d  = cmd_i.down ? E_DNL : E_UPRD;
        end
      end
      E_UPRD: begin
        if (i_q == '0) begin
          we_o    = 1'b1;
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          re_o    = 1'b1;
          state_d = E_UPCMP;
        end
      end
      E_UPCMP: begin
        we_o = 1'b1;
        if (rmth_pkg::outranks(x_q, rdata_i, is_max_q)) begin
          wdata_o = rdata_i;
          i_d     = parent;
          state_d = E_UPRD;
        end else begin
          done_o  = 1'b1;
          state_d = E_IDLE;
        end
      end
      E_DNL: begin
        if (left_w >= n_w) begin
          we_o    = 1'b1;
          done_o  = 1'b1;
          state_d = E_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(left_w);
          state_d = E_DNR;
        end
      end
      E_DNR: begin
        cl_d     = rdata_i;
        have_r_d = right_w < n_w;
        re_o     = right_w < n_w;
        raddr_o  = AW'(right_w);
        state_d  = E_DNCMP;
      end
      E_DNCMP: begin
        we_o = 1'b1;
        if (pick_r) begin
          wdata_o = rdata_i;
          i_d     = AW'(right_w);
          state_d = E_DNL;
        end else if (pick_l) begin
          wdata_o = cl_q;
          i_d     = AW'(left_w);
          state_d = E_DNL;
        end else begin
          done_o  = 1'b1;
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_max_q <= is_max_d;
    i_q      <= i_d;
    n_q      <= n_d;
    x_q      <= x_d;
    cl_q     <= cl_d;
    have_r_q <= have_r_d;
  end

endmodule

// ===== hw/rtl/running_median_two_heap_unit.sv =====
// Running median over a stream of signed samples, kept in a max-heap and a min-heap.
// Depends on rmth_pkg, rmth_ram and rmth_sift.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, value_i             | sample in
//  out     | out_valid_o, out_ready_i, median_doubled_o, | result out
//          | held_count_o, dropped_o                     |
//
// One item at a time. An item passes through the control steps accept, upper push
// issue, pop read, pop issue, lower push issue and result load, plus its sifts:
// a sift down reads the left child, reads the right child and compares per level;
// a sift up reads the parent and compares per level; a sift that reaches a leaf
// or the root ends with a closing write. Each heap RAM has a single read port.
// An item with no pop skips the pop and lower push steps. A sample taken at a
// full store goes straight to the result load. Reset clears the state, the fill
// counts and the output valid flag; heap RAM content is never cleared. A result
// waiting in the output register does not stop the next beat from being taken;
// only its own result then waits.
module running_median_two_heap_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rmth_pkg::DataW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rmth_pkg::MedW-1:0]    median_doubled_o,
  output logic [rmth_pkg::CountW-1:0]         held_count_o,
  output logic                                dropped_o
);

  localparam int unsigned Slots = CAPACITY / 2 + 1;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned SW    = $clog2(Slots + 1);
  localparam int unsigned HW    = SW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_W1    = 4'd1;
  localparam logic [3:0] S_PUSHU = 4'd2;
  localparam logic [3:0] S_W2    = 4'd3;
  localparam logic [3:0] S_POPRD = 4'd4;
  localparam logic [3:0] S_POPDN = 4'd5;
  localparam logic [3:0] S_W3    = 4'd6;
  localparam logic [3:0] S_PUSHL = 4'd7;
  localparam logic [3:0] S_W4    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]                          state_q, state_d;
  logic [SW-1:0]                       lower_size_q, lower_size_d;
  logic [SW-1:0]                       upper_size_q, upper_size_d;
  logic signed [rmth_pkg::DataW-1:0]   lower_top_q, lower_top_d;
  logic signed [rmth_pkg::DataW-1:0]   upper_top_q, upper_top_d;
  logic signed [rmth_pkg::DataW-1:0]   t_q, t_d;
  logic signed [rmth_pkg::DataW-1:0]   u_q, u_d;
  logic                                full_q, full_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [rmth_pkg::MedW-1:0]    med_q, med_d;
  logic [rmth_pkg::CountW-1:0]         cnt_q, cnt_d;
  logic                                drop_q, drop_d;

  logic [HW-1:0]                       held;
  logic                                in_fire, out_fire, load_out;
  logic signed [rmth_pkg::MedW-1:0]    med_now;

  rmth_pkg::heap_cmd_t                 eng_cmd;
  logic [AW-1:0]                       eng_idx;
  logic [SW-1:0]                       eng_n;
  logic signed [rmth_pkg::DataW-1:0]   eng_x;
  logic                                eng_done, eng_sel_lower, eng_we, eng_re;
  logic [AW-1:0]                       eng_waddr, eng_raddr;
  logic [rmth_pkg::DataW-1:0]          eng_wdata;
  logic signed [rmth_pkg::DataW-1:0]   eng_rdata;

  logic                                pop_re;
  logic [AW-1:0]                       pop_addr;
  logic [rmth_pkg::DataW-1:0]          lower_rdata, upper_rdata;

  assign held     = HW'(lower_size_q) + HW'(upper_size_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // doubled median: zero when empty, exact 33-bit sum of tops, or twice the lower top
  always_comb begin
    if (lower_size_q == '0) begin
      med_now = '0;
    end else if (lower_size_q == upper_size_q) begin
      med_now = {lower_top_q[rmth_pkg::DataW-1], lower_top_q}
              + {upper_top_q[rmth_pkg::DataW-1], upper_top_q};
    end else begin
      med_now = {lower_top_q, 1'b0};
    end
  end

  always_comb begin
    state_d      = state_q;
    lower_size_d = lower_size_q;
    upper_size_d = upper_size_q;
    t_d          = t_q;
    u_d          = u_q;
    full_d       = full_q;
    eng_cmd      = '0;
    eng_idx      = '0;
    eng_n        = lower_size_q;
    eng_x        = value_i;
    pop_re       = 1'b0;
    pop_addr     = AW'(upper_size_q - SW'(1));
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          full_d = held >= HW'(CAPACITY);
          if (held >= HW'(CAPACITY)) begin
            state_d = S_OUT;
          end else if (lower_size_q != '0 && value_i < lower_top_q) begin
            // swap the sample into the lower root, sift it down
            t_d            = lower_top_q;
            eng_cmd.start  = 1'b1;
            eng_cmd.is_max = 1'b1;
            eng_cmd.down   = 1'b1;
            state_d        = S_W1;
          end else begin
            t_d     = value_i;
            state_d = S_PUSHU;
          end
        end
      end
      S_W1: begin
        if (eng_done) state_d = S_PUSHU;
      end
      S_PUSHU: begin
        eng_cmd.start = 1'b1;
        eng_idx       = AW'(upper_size_q);
        eng_x         = t_q;
        upper_size_d  = upper_size_q + SW'(1);
        state_d       = S_W2;
      end
      S_W2: begin
        if (eng_done) state_d = (lower_size_q < upper_size_q) ? S_POPRD : S_OUT;
      end
      S_POPRD: begin
        // take the upper top, fetch the last entry to refill the root
        u_d          = upper_top_q;
        upper_size_d = upper_size_q - SW'(1);
        pop_re       = 1'b1;
        state_d      = S_POPDN;
      end
      S_POPDN: begin
        eng_cmd.start = 1'b1;
        eng_cmd.down  = 1'b1;
        eng_n         = upper_size_q;
        eng_x         = upper_rdata;
        state_d       = S_W3;
      end
      S_W3: begin
        if (eng_done) state_d = S_PUSHL;
      end
      S_PUSHL: begin
        eng_cmd.start  = 1'b1;
        eng_cmd.is_max = 1'b1;
        eng_idx        = AW'(lower_size_q);
        eng_x          = u_q;
        lower_size_d   = lower_size_q + SW'(1);
        state_d        = S_W4;
      end
      S_W4: begin
        if (eng_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // keep both roots in registers: track every write to entry zero
  always_comb begin
    lower_top_d = lower_top_q;
    upper_top_d = upper_top_q;
    if (eng_we && eng_waddr == '0) begin
      if (eng_sel_lower) lower_top_d = eng_wdata;
      else               upper_top_d = eng_wdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    med_d       = med_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    if (out_fire) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      med_d       = med_now;
      cnt_d       = rmth_pkg::CountW'(held);
      drop_d      = full_q;
    end
  end

  rmth_sift #(.Slots(Slots)) u_sift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (eng_cmd),
    .idx_i       (eng_idx),
    .n_i         (eng_n),
    .x_i         (eng_x),
    .done_o      (eng_done),
    .sel_lower_o (eng_sel_lower),
    .we_o        (eng_we),
    .waddr_o     (eng_waddr),
    .wdata_o     (eng_wdata),
    .re_o        (eng_re),
    .raddr_o     (eng_raddr),
    .rdata_i     (eng_rdata)
  );

  assign eng_rdata = eng_sel_lower ? lower_rdata : upper_rdata;

  rmth_ram #(.Width(rmth_pkg::DataW), .Depth(Slots)) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (eng_we && eng_sel_lower),
    .waddr_i (eng_waddr),
    .wdata_i (eng_wdata),
    .re_i    (eng_re && eng_sel_lower),
    .raddr_i (eng_raddr),
    .rdata_o (lower_rdata)
  );

  rmth_ram #(.Width(rmth_pkg::DataW), .Depth(Slots)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (eng_we && !eng_sel_lower),
    .waddr_i (eng_waddr),
    .wdata_i (eng_wdata),
    .re_i    ((eng_re && !eng_sel_lower) || pop_re),
    .raddr_i (pop_re ? pop_addr : eng_raddr),
    .rdata_o (upper_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lower_size_q <= '0;
      upper_size_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lower_size_q <= lower_size_d;
      upper_size_q <= upper_size_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lower_top_q <= lower_top_d;
    upper_top_q <= upper_top_d;
    t_q         <= t_d;
    u_q         <= u_d;
    full_q      <= full_d;
    med_q       <= med_d;
    cnt_q       <= cnt_d;
    drop_q      <= drop_d;
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign held_count_o     = cnt_q;
  assign dropped_o        = drop_q;

endmodule

// ===== hw/rtl/rmth_checker.sv =====
// Port-level checks for the running median unit, bound to the top level.
// Depends on running_median_two_heap_unit and rmth_pkg.
module rmth_checker #(
  parameter int unsigned Capacity = 1024
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [rmth_pkg::DataW-1:0]   value_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [rmth_pkg::MedW-1:0]    median_doubled_o,
  input logic [rmth_pkg::CountW-1:0]         held_count_o,
  input logic                                dropped_o
);

  // hold a waiting sample beat
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("waiting sample changed");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("stalled result changed");

  // every result reports at least one held value
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> held_count_o != '0)
    else $error("result with empty store");

  // drop only when the store is at capacity
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> held_count_o == rmth_pkg::CountW'(Capacity))
    else $error("drop below capacity");

  // an odd count takes the middle value, so the doubled median is even
  a_odd_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_count_o[0] |-> !median_doubled_o[0])
    else $error("odd count with odd doubled median");

endmodule

bind running_median_two_heap_unit rmth_checker #(.Capacity(CAPACITY)) u_rmth_checker (.*);
